@@ hdl/iee_pkg.sv @@
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants for the infix expression evaluator.
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int NUM_WIDTH = 32;
    localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);

    typedef logic [NUM_WIDTH-1:0] num_t;

    // operator codes
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // token phase
    typedef enum logic [1:0] {
        TK_EMPTY  = 2'd0,
        TK_DIGITS = 2'd1,
        TK_DONE   = 2'd2,
        TK_BAD    = 2'd3
    } tok_t;

    // command from front to back
    typedef enum logic [1:0] {
        CMD_NUM_OP   = 2'd0,
        CMD_NUM_LAST = 2'd1,
        CMD_BOTH     = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        num_t      num;
        logic      missing;
        op_t       op;
    } cmd_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_RED_OP,
        BK_RED_LAST,
        BK_DIV,
        BK_MUL,
        BK_OUT
    } bk_state_t;

    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIV0 = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    localparam int QDEPTH = 2;

endpackage

@@ hdl/iee_char_if.sv @@
// ----------------------------------------------------------------------------
// iee_char_if
// Character input channel: valid/ready with one character per word.
// ----------------------------------------------------------------------------
interface iee_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

@@ hdl/iee_result_if.sv @@
// ----------------------------------------------------------------------------
// iee_result_if
// Result output channel: valid/ready with value and status.
// ----------------------------------------------------------------------------
interface iee_result_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] value;
    logic [1:0]        status;

    modport source (output valid, output value, output status, input ready);
    modport sink (input valid, input value, input status, output ready);
endinterface

@@ hdl/infix_expression_evaluator_unit.sv @@
// ----------------------------------------------------------------------------
// infix_expression_evaluator_unit
// Character-stream infix evaluator for + - * / over decimal operands.
// ----------------------------------------------------------------------------
// Characters that are not operators are taken one per cycle by the tokenizer
// while the two-entry command queue has room. Each operator, and the final
// character, sends a command word through the queue to the evaluator; an
// operator that also ends the expression becomes two words. The evaluator
// takes a word only while idle and reduces it: an add or subtract in place, a
// multiply through the registered product and a divide in the one-bit-per-cycle
// divider, at most two reductions per word. An operator word then pushes its
// operator; the final word loads the result register, which holds until the
// result is taken.
module infix_expression_evaluator_unit (
    input  logic         clk,
    input  logic         rst_n,
    iee_char_if.sink     chars,
    iee_result_if.source result
);

    logic          f_valid, f_ready;
    iee_pkg::cmd_t f_cmd;
    logic          q_valid, q_ready;
    iee_pkg::cmd_t q_cmd;
    logic          s_valid, s_ready;
    iee_pkg::cmd_t s_cmd;

    iee_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    iee_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

    iee_last_stage u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_cmd    (q_cmd),
        .out_valid (s_valid),
        .out_ready (s_ready),
        .out_cmd   (s_cmd)
    );

    iee_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd       (s_cmd),
        .res       (result)
    );

    // status never takes the unused code
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.status != 2'd3)
        else $error("status code out of range");

    // result word holds while stalled
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(result.value))
        else $error("result changed while stalled");

    // queue never overflows into the tokenizer
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        f_valid && !f_ready |-> q_valid)
        else $error("queue full without pending word");

endmodule

@@ hdl/iee_front.sv @@
// ----------------------------------------------------------------------------
// iee_front
// Tokenizer: gathers operand digits and emits a command word per operator
// or final character.
// ----------------------------------------------------------------------------
module iee_front (
    input  logic              clk,
    input  logic              rst_n,
    iee_char_if.sink          chars,
    output logic              cmd_valid,
    output iee_pkg::cmd_t     cmd,
    input  logic              cmd_ready
);

    iee_pkg::num_t tok_val_reg, tok_val_next;
    iee_pkg::tok_t tok_ph_reg, tok_ph_next;
    logic          is_op, is_digit, is_space;
    iee_pkg::op_t  op_code;
    logic          accept;
    iee_pkg::num_t digit_val;

    assign chars.ready = cmd_ready;
    assign accept      = chars.valid && chars.ready;

    // classify character
    always_comb
    begin
        is_op   = 1'b1;
        op_code = iee_pkg::OP_ADD;
        case (chars.char_code)
            iee_pkg::CH_ADD: op_code = iee_pkg::OP_ADD;
            iee_pkg::CH_SUB: op_code = iee_pkg::OP_SUB;
            iee_pkg::CH_MUL: op_code = iee_pkg::OP_MUL;
            iee_pkg::CH_DIV: op_code = iee_pkg::OP_DIV;
            default:         is_op   = 1'b0;
        endcase
        is_digit  = chars.char_code >= iee_pkg::CH_0 && chars.char_code <= iee_pkg::CH_9;
        is_space  = chars.char_code == 8'd32
                    || (chars.char_code >= 8'd9 && chars.char_code <= 8'd13);
        digit_val = iee_pkg::num_t'(chars.char_code - iee_pkg::CH_0);
    end

    // token after this character, before any take
    iee_pkg::num_t fed_val;
    iee_pkg::tok_t fed_ph;
    always_comb
    begin
        fed_val = tok_val_reg;
        fed_ph  = tok_ph_reg;
        if (!is_op)
        begin
            case (tok_ph_reg)
                iee_pkg::TK_EMPTY:
                begin
                    if (is_digit)
                    begin
                        fed_val = digit_val;
                        fed_ph  = iee_pkg::TK_DIGITS;
                    end
                    else if (!is_space)
                        fed_ph = iee_pkg::TK_BAD;
                end
                iee_pkg::TK_DIGITS:
                begin
                    if (is_digit)
                        fed_val = (tok_val_reg << 3) + (tok_val_reg << 1) + digit_val;
                    else
                        fed_ph = iee_pkg::TK_DONE;
                end
                default: ;
            endcase
        end
    end

    // command word
    always_comb
    begin
        cmd.op      = op_code;
        cmd.num     = (tok_ph_reg == iee_pkg::TK_DIGITS || tok_ph_reg == iee_pkg::TK_DONE)
                      ? tok_val_reg : '0;
        cmd.missing = !(tok_ph_reg == iee_pkg::TK_DIGITS || tok_ph_reg == iee_pkg::TK_DONE);
        if (is_op && chars.last_char)
            cmd.kind = iee_pkg::CMD_BOTH;
        else if (is_op)
            cmd.kind = iee_pkg::CMD_NUM_OP;
        else
        begin
            cmd.kind    = iee_pkg::CMD_NUM_LAST;
            cmd.num     = (fed_ph == iee_pkg::TK_DIGITS || fed_ph == iee_pkg::TK_DONE)
                          ? fed_val : '0;
            cmd.missing = !(fed_ph == iee_pkg::TK_DIGITS || fed_ph == iee_pkg::TK_DONE);
        end
        cmd_valid = chars.valid && (is_op || chars.last_char);
    end

    // token registers
    always_comb
    begin
        tok_val_next = tok_val_reg;
        tok_ph_next  = tok_ph_reg;
        if (accept)
        begin
            if (is_op || chars.last_char)
            begin
                tok_val_next = '0;
                tok_ph_next  = iee_pkg::TK_EMPTY;
            end
            else
            begin
                tok_val_next = fed_val;
                tok_ph_next  = fed_ph;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_val_reg <= '0;
            tok_ph_reg  <= iee_pkg::TK_EMPTY;
        end
        else
        begin
            tok_val_reg <= tok_val_next;
            tok_ph_reg  <= tok_ph_next;
        end
    end

endmodule

@@ hdl/iee_queue.sv @@
// ----------------------------------------------------------------------------
// iee_queue
// Small command queue between the tokenizer and the evaluator.
// ----------------------------------------------------------------------------
module iee_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  iee_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output iee_pkg::cmd_t out_cmd
);

    localparam int AW = $clog2(iee_pkg::QDEPTH);

    iee_pkg::cmd_t    mem [iee_pkg::QDEPTH];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [AW:0]      cnt_reg;
    logic             push, pop;

    assign in_ready  = cnt_reg != (AW+1)'(iee_pkg::QDEPTH);
    assign out_valid = cnt_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_cmd   = mem[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= in_cmd;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

@@ hdl/iee_divider.sv @@
// ----------------------------------------------------------------------------
// iee_divider
// Radix-2 restoring signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iee_divider (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  iee_pkg::num_t a,
    input  iee_pkg::num_t b,
    output logic          done,
    output iee_pkg::num_t q
);

    localparam int W = iee_pkg::NUM_WIDTH;

    iee_pkg::num_t                 rem_reg, quo_reg, dvs_reg;
    logic                          neg_reg, busy_reg;
    logic [iee_pkg::CNT_WIDTH-1:0] cnt_reg;
    logic [W:0]                    trial;

    assign trial = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};
    assign done  = busy_reg && cnt_reg == '0;
    assign q     = neg_reg ? -quo_reg : quo_reg;

    // shift-subtract loop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= iee_pkg::CNT_WIDTH'(W);
        end
        else if (done)
            busy_reg <= 1'b0;
        else if (busy_reg)
            cnt_reg <= cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= a[W-1] ? -a : a;
            dvs_reg <= b[W-1] ? -b : b;
            neg_reg <= a[W-1] ^ b[W-1];
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

endmodule

@@ hdl/iee_back.sv @@
// ----------------------------------------------------------------------------
// iee_back
// Evaluator: number and operator stacks, reduction sequencer, result register.
// ----------------------------------------------------------------------------
module iee_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  iee_pkg::cmd_t cmd,
    iee_result_if.source  res
);

    iee_pkg::bk_state_t state_reg, state_next;
    iee_pkg::num_t      ns_reg [3];
    iee_pkg::op_t       os_reg [2];
    logic [1:0]         nc_reg, oc_reg;
    logic [1:0]         err_reg;
    iee_pkg::cmd_t      cur_reg;
    iee_pkg::num_t      prod_reg;
    logic               mul_wait_reg;
    logic               div_start;
    logic               div_done;
    iee_pkg::num_t      div_q;
    logic               out_valid_reg;
    logic signed [31:0] out_val_reg;
    logic [1:0]         out_st_reg;

    iee_pkg::num_t lhs, rhs;
    iee_pkg::op_t  top_op;
    logic          can_red, want_red_op;

    iee_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (lhs),
        .b     (rhs),
        .done  (div_done),
        .q     (div_q)
    );

    assign lhs    = ns_reg[nc_reg - 2'd2];
    assign rhs    = ns_reg[nc_reg - 2'd1];
    assign top_op = os_reg[oc_reg[0] ? 1'b0 : 1'b1];
    assign can_red = oc_reg != '0 && nc_reg >= 2'd2;
    assign want_red_op = oc_reg != '0
        && !(cur_reg.op >= iee_pkg::OP_MUL && top_op < iee_pkg::OP_MUL);

    assign cmd_ready = state_reg == iee_pkg::BK_IDLE;
    assign res.valid  = out_valid_reg;
    assign res.value  = out_val_reg;
    assign res.status = out_st_reg;

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        case (state_reg)
            iee_pkg::BK_IDLE:
                if (cmd_valid)
                    state_next = (cmd.kind == iee_pkg::CMD_NUM_OP)
                                 ? iee_pkg::BK_RED_OP : iee_pkg::BK_RED_LAST;
            iee_pkg::BK_RED_OP, iee_pkg::BK_RED_LAST:
            begin
                if ((state_reg == iee_pkg::BK_RED_OP && !want_red_op)
                    || (state_reg == iee_pkg::BK_RED_LAST && oc_reg == '0))
                    state_next = (state_reg == iee_pkg::BK_RED_OP)
                                 ? iee_pkg::BK_IDLE : iee_pkg::BK_OUT;
                else if (can_red && top_op == iee_pkg::OP_DIV && rhs != '0)
                begin
                    div_start  = 1'b1;
                    state_next = iee_pkg::BK_DIV;
                end
                else if (can_red && top_op == iee_pkg::OP_MUL)
                    state_next = iee_pkg::BK_MUL;
            end
            iee_pkg::BK_DIV:
                if (div_done)
                    state_next = cur_reg.kind == iee_pkg::CMD_NUM_OP
                                 ? iee_pkg::BK_RED_OP : iee_pkg::BK_RED_LAST;
            iee_pkg::BK_MUL:
                if (!mul_wait_reg)
                    state_next = cur_reg.kind == iee_pkg::CMD_NUM_OP
                                 ? iee_pkg::BK_RED_OP : iee_pkg::BK_RED_LAST;
            iee_pkg::BK_OUT:
                if (!out_valid_reg || res.ready)
                    state_next = iee_pkg::BK_IDLE;
            default: state_next = iee_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= iee_pkg::BK_IDLE;
        else
            state_reg <= state_next;
    end

    // stacks and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg        <= '0;
            oc_reg        <= '0;
            err_reg       <= '0;
            mul_wait_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_val_reg   <= '0;
            out_st_reg    <= iee_pkg::ST_OK;
            cur_reg       <= '0;
            prod_reg      <= '0;
            ns_reg        <= '{default: '0};
            os_reg        <= '{default: iee_pkg::OP_ADD};
        end
        else
        begin
            // result word valid: load in the output state, clear when taken
            if (state_reg == iee_pkg::BK_OUT && (!out_valid_reg || res.ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && res.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                iee_pkg::BK_IDLE:
                    if (cmd_valid)
                    begin
                        cur_reg <= cmd;
                        if (cmd.missing)
                            err_reg[1] <= 1'b1;
                        if (nc_reg != 2'd3)
                        begin
                            ns_reg[nc_reg] <= cmd.num;
                            nc_reg         <= nc_reg + 1'b1;
                        end
                    end
                iee_pkg::BK_RED_OP, iee_pkg::BK_RED_LAST:
                begin
                    if ((state_reg == iee_pkg::BK_RED_OP && !want_red_op)
                        || (state_reg == iee_pkg::BK_RED_LAST && oc_reg == '0))
                    begin
                        if (state_reg == iee_pkg::BK_RED_OP)
                        begin
                            if (oc_reg != 2'd2)
                            begin
                                os_reg[oc_reg[0]] <= cur_reg.op;
                                oc_reg            <= oc_reg + 1'b1;
                            end
                        end
                    end
                    else if (!can_red)
                        oc_reg <= oc_reg - 1'b1;
                    else if (top_op == iee_pkg::OP_ADD || top_op == iee_pkg::OP_SUB
                             || (top_op == iee_pkg::OP_DIV && rhs == '0))
                    begin
                        oc_reg <= oc_reg - 1'b1;
                        nc_reg <= nc_reg - 1'b1;
                        if (top_op == iee_pkg::OP_ADD)
                            ns_reg[nc_reg - 2'd2] <= lhs + rhs;
                        else if (top_op == iee_pkg::OP_SUB)
                            ns_reg[nc_reg - 2'd2] <= lhs - rhs;
                        else
                        begin
                            ns_reg[nc_reg - 2'd2] <= '0;
                            err_reg[0]            <= 1'b1;
                        end
                    end
                    else if (top_op == iee_pkg::OP_MUL)
                    begin
                        prod_reg     <= lhs * rhs;
                        mul_wait_reg <= 1'b1;
                    end
                end
                iee_pkg::BK_MUL:
                    if (mul_wait_reg)
                    begin
                        mul_wait_reg          <= 1'b0;
                        ns_reg[nc_reg - 2'd2] <= prod_reg;
                        oc_reg                <= oc_reg - 1'b1;
                        nc_reg                <= nc_reg - 1'b1;
                    end
                iee_pkg::BK_DIV:
                    if (div_done)
                    begin
                        ns_reg[nc_reg - 2'd2] <= div_q;
                        oc_reg                <= oc_reg - 1'b1;
                        nc_reg                <= nc_reg - 1'b1;
                    end
                iee_pkg::BK_OUT:
                    if (!out_valid_reg || res.ready)
                    begin
                        out_val_reg   <= (nc_reg != '0) ? 32'(ns_reg[nc_reg - 2'd1]) : '0;
                        out_st_reg    <= err_reg[0] ? iee_pkg::ST_DIV0
                                       : (err_reg[1] ? iee_pkg::ST_MISS : iee_pkg::ST_OK);
                        nc_reg        <= '0;
                        oc_reg        <= '0;
                        err_reg       <= '0;
                    end
                default: ;
            endcase
        end
    end

endmodule

@@ hdl/iee_last_stage.sv @@
// ----------------------------------------------------------------------------
// iee_last_stage
// Splits an operator that also ends the expression into two command words.
// ----------------------------------------------------------------------------
module iee_last_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  iee_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output iee_pkg::cmd_t out_cmd
);

    logic second_reg;

    // first word pushes operand and operator, second closes with an empty operand
    always_comb
    begin
        out_valid = in_valid;
        out_cmd   = in_cmd;
        in_ready  = out_ready;
        if (in_cmd.kind == iee_pkg::CMD_BOTH)
        begin
            if (!second_reg)
            begin
                out_cmd.kind = iee_pkg::CMD_NUM_OP;
                in_ready     = 1'b0;
            end
            else
            begin
                out_cmd.kind    = iee_pkg::CMD_NUM_LAST;
                out_cmd.num     = '0;
                out_cmd.missing = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else if (in_valid && out_ready && in_cmd.kind == iee_pkg::CMD_BOTH)
            second_reg <= !second_reg;
    end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the infix expression evaluator. Expressions go in
// one character per word, and each result is checked against a behavioral
// two-stack evaluator. The run covers directed corner cases, a backpressure
// phase and random expressions with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  status;
    } outcome_t;

    logic clk;
    logic rst_n;
    iee_char_if   chars ();
    iee_result_if result ();

    infix_expression_evaluator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .result (result)
    );

    // evaluator state mirrored by the bench
    logic [31:0]   num_stk [3];
    int            num_cnt;
    iee_pkg::op_t  op_stk [2];
    int            op_cnt;
    logic [31:0]   tok_val;
    iee_pkg::tok_t tok_ph;
    logic [1:0]    err_flags;

    outcome_t pending_outcomes[$];
    int       mismatch_count;
    bit       send_gaps;
    bit       recv_gaps;
    int       hold_cycles;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // receiver ready, with random gaps and a counted hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles = hold_cycles - 1;
            result.ready = 1'b0;
        end
        else
        begin
            result.ready = !(recv_gaps && $urandom_range(0, 99) < 24);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        outcome_t exp_o;
        if (rst_n && result.valid && result.ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result word with none expected: value %0d status %0d",
                       result.value, result.status);
                mismatch_count++;
            end
            else
            begin
                exp_o = pending_outcomes.pop_front();
                if (result.value !== exp_o.value)
                begin
                    $error("value: expected %0d actual %0d",
                           $signed(exp_o.value), result.value);
                    mismatch_count++;
                end
                if (result.status !== exp_o.status)
                begin
                    $error("status: expected %0d actual %0d", exp_o.status, result.status);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void clear_eval();
        num_cnt   = 0;
        op_cnt    = 0;
        tok_val   = '0;
        tok_ph    = iee_pkg::TK_EMPTY;
        err_flags = 2'b00;
    endfunction

    function automatic logic [31:0] combine(logic [31:0] a, logic [31:0] b,
                                            iee_pkg::op_t op);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        case (op)
            iee_pkg::OP_ADD: return a + b;
            iee_pkg::OP_SUB: return a - b;
            iee_pkg::OP_MUL: return a * b;
            default:
            begin
                ua = a[31] ? -a : a;
                ub = b[31] ? -b : b;
                if (ub == 0)
                begin
                    err_flags[0] = 1'b1;
                    return '0;
                end
                q = ua / ub;
                return (a[31] != b[31]) ? -q : q;
            end
        endcase
    endfunction

    function automatic void push_num(logic [31:0] v);
        if (num_cnt < 3)
        begin
            num_stk[num_cnt] = v;
            num_cnt++;
        end
    endfunction

    function automatic void reduce_top();
        logic [31:0] lhs;
        logic [31:0] rhs;
        if (op_cnt == 0 || num_cnt < 2)
            return;
        op_cnt--;
        rhs = num_stk[num_cnt-1];
        lhs = num_stk[num_cnt-2];
        num_cnt -= 2;
        push_num(combine(lhs, rhs, op_stk[op_cnt]));
    endfunction

    function automatic void close_token();
        if (tok_ph == iee_pkg::TK_DIGITS || tok_ph == iee_pkg::TK_DONE)
            push_num(tok_val);
        else
        begin
            err_flags[1] = 1'b1;
            push_num('0);
        end
        tok_val = '0;
        tok_ph  = iee_pkg::TK_EMPTY;
    endfunction

    // advance the evaluator by one character, queue the outcome on the last one
    function automatic void evaluate_char(logic [7:0] c, logic last);
        bit           is_op;
        iee_pkg::op_t op;
        bit           space;
        bit           digit;
        outcome_t     o;
        is_op = 1'b1;
        op    = iee_pkg::OP_ADD;
        space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
        digit = (c >= iee_pkg::CH_0 && c <= iee_pkg::CH_9);
        case (c)
            iee_pkg::CH_ADD: op = iee_pkg::OP_ADD;
            iee_pkg::CH_SUB: op = iee_pkg::OP_SUB;
            iee_pkg::CH_MUL: op = iee_pkg::OP_MUL;
            iee_pkg::CH_DIV: op = iee_pkg::OP_DIV;
            default: is_op = 1'b0;
        endcase
        if (is_op)
        begin
            close_token();
            while (op_cnt > 0 && !(op >= iee_pkg::OP_MUL
                                   && op_stk[op_cnt-1] < iee_pkg::OP_MUL))
                reduce_top();
            if (op_cnt < 2)
            begin
                op_stk[op_cnt] = op;
                op_cnt++;
            end
        end
        else if (tok_ph == iee_pkg::TK_EMPTY)
        begin
            if (digit)
            begin
                tok_val = 32'(c - iee_pkg::CH_0);
                tok_ph  = iee_pkg::TK_DIGITS;
            end
            else if (!space)
                tok_ph = iee_pkg::TK_BAD;
        end
        else if (tok_ph == iee_pkg::TK_DIGITS)
        begin
            if (digit)
                tok_val = tok_val * 10 + 32'(c - iee_pkg::CH_0);
            else
                tok_ph = iee_pkg::TK_DONE;
        end
        if (last)
        begin
            close_token();
            while (op_cnt > 0)
                reduce_top();
            o.value  = (num_cnt > 0) ? num_stk[num_cnt-1] : '0;
            o.status = err_flags[0] ? iee_pkg::ST_DIV0
                     : (err_flags[1] ? iee_pkg::ST_MISS : iee_pkg::ST_OK);
            pending_outcomes.insert(pending_outcomes.size(), o);
            clear_eval();
        end
    endfunction

    // offer one character word and wait until it is taken
    task automatic send_char(logic [7:0] c, logic last);
        @(negedge clk);
        while (send_gaps && $urandom_range(0, 99) < 24)
        begin
            chars.valid = 1'b0;
            @(negedge clk);
        end
        chars.valid     = 1'b1;
        chars.char_code = c;
        chars.last_char = last;
        // ready only moves at the rising edge, so it is stable here
        while (!chars.ready)
            @(negedge clk);
        @(posedge clk);
        evaluate_char(c, last);
    endtask

    task automatic send_expr(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        chars.valid = 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    // precedence, associativity and all four operators
    task automatic test_operators();
        send_expr("1+2*3");
        send_expr("8-3-2");
        send_expr("100/7/2");
        send_expr("2*3+4*5-6/2");
        send_expr("7-10");
        send_expr("0");
        send_expr("4294967295*4294967295");
        drain();
    endtask

    // error paths and token corner cases
    task automatic test_corner_cases();
        send_expr("5/0");
        send_expr("2147483648/4294967295");
        send_expr("+");
        send_expr("5+");
        send_expr(" ");
        send_expr(" \t 42 ");
        send_expr("a+3");
        send_expr("12a3+4");
        send_expr("99999999999");
        send_expr("/0");
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
        drain();
    endtask

    function automatic string random_expr();
        string s;
        string ops;
        int n_operands;
        int n_digits;
        ops = "+-*/";
        s = "";
        n_operands = $urandom_range(1, 5);
        for (int k = 0; k < n_operands; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                s = {s, " "};
            n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12)
                                                   : $urandom_range(1, 3);
            for (int d = 0; d < n_digits; d++)
                s = {s, string'(8'(iee_pkg::CH_0 + $urandom_range(0, 9)))};
            if ($urandom_range(0, 11) == 0)
                s = {s, string'(8'($urandom_range(0, 255)))};
            if (k != n_operands - 1)
                s = {s, string'(ops[$urandom_range(0, 3)])};
        end
        if ($urandom_range(0, 19) == 0)
            s = {s, string'(ops[$urandom_range(0, 3)])};
        return s;
    endfunction

    // hold the result side off while words keep coming, then let it drain
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_expr(random_expr());
        drain();
    endtask

    // random expressions, first without gaps, then with gaps on both sides
    task automatic test_random();
        int sent;
        string s;
        sent = 0;
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        while (sent < 720)
        begin
            if (sent > 150)
            begin
                send_gaps = 1'b1;
                recv_gaps = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                s = random_expr();
                send_expr(s);
                sent += s.len();
            end
        end
        send_char(iee_pkg::CH_0, 1'b1);
        drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        chars.valid     = 1'b0;
        chars.char_code = '0;
        chars.last_char = 1'b0;
        result.ready    = 1'b0;
        send_gaps       = 1'b1;
        recv_gaps       = 1'b1;
        hold_cycles     = 0;
        mismatch_count  = 0;
        clear_eval();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_operators();
        test_corner_cases();
        test_backpressure();
        test_random();
        if (mismatch_count == 0)
            $display("infix_expression_evaluator_unit regression: pass");
        else
            $display("infix_expression_evaluator_unit regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #50000000;
        $display("infix_expression_evaluator_unit regression: fail");
        $finish;
    end
endmodule
